// ----- hdl/assert_macros.svh -----
// Assertion helpers used by spq_core. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- hdl/spq_pkg.sv -----
package spq_pkg;

	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                is_empty;
		logic [COUNT_W-1:0]  entry_count;
		logic [VALUE_W-1:0]  top_value;
	} spq_result_t;

	// Signed greater-than done as an unsigned compare on sign-flipped keys.
	function automatic logic key_gt(input logic [VALUE_W-1:0] a,
	                                input logic [VALUE_W-1:0] b);
		return {~a[VALUE_W-1], a[VALUE_W-2:0]} > {~b[VALUE_W-1], b[VALUE_W-2:0]};
	endfunction

endpackage

// ----- hdl/spq_ram.sv -----
module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hdl/spq_core.sv -----
`include "assert_macros.svh"

module spq_core #(
	parameter int CAPACITY = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             start_opcode,
	input  logic [spq_pkg::VALUE_W-1:0]      start_value,
	output logic                             idle,
	output logic                             res_valid,
	input  logic                             res_ready,
	output spq_pkg::spq_result_t             result,
	output logic                             wr_en,
	output logic [$clog2(CAPACITY)-1:0]      wr_addr,
	output logic [spq_pkg::VALUE_W-1:0]      wr_data,
	output logic                             rd_en,
	output logic [$clog2(CAPACITY)-1:0]      rd_addr,
	input  logic [spq_pkg::VALUE_W-1:0]      rd_data
);
	import spq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PRD   = 3'd1;
	localparam logic [2:0] S_PCMP  = 3'd2;
	localparam logic [2:0] S_PLAST = 3'd3;
	localparam logic [2:0] S_QRD   = 3'd4;
	localparam logic [2:0] S_QWR   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       idx_q;
	logic [VALUE_W-1:0]  val_q;
	logic [VALUE_W-1:0]  top_q;
	logic [STATUS_W-1:0] status_q;
	logic                gt;

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign gt        = key_gt(rd_data, val_q);

	assign result.top_value   = top_q;
	assign result.entry_count = COUNT_W'(cnt_q);
	assign result.is_empty    = (cnt_q == CW'(0));
	assign result.status      = status_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		rd_en   = 1'b0;
		rd_addr = idx_q - AW'(1);
		case (state_q)
			S_IDLE: begin
				if (start && start_opcode == OP_PUSH && cnt_q == CW'(0)) begin
					wr_en   = 1'b1;
					wr_data = start_value;
				end
			end
			S_PRD: begin
				rd_en = 1'b1;
			end
			S_PCMP: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = gt ? val_q : rd_data;
			end
			S_PLAST: begin
				wr_en = 1'b1;
			end
			S_QRD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			S_QWR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q - AW'(1);
				wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	// Push walks from the tail toward the head, moving each smaller-or-equal
	// entry down one slot until a strictly larger entry is found. Pop moves
	// every entry up one slot. Both use one RAM read per slot; push also compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
			top_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q    <= start_value;
						status_q <= ST_OK;
						state_q  <= S_DONE;
						if (start_opcode == OP_PUSH) begin
							if (cnt_q == CW'(CAPACITY)) begin
								status_q <= ST_FULL;
							end else if (cnt_q == CW'(0)) begin
								top_q <= start_value;
								cnt_q <= CW'(1);
							end else begin
								idx_q   <= cnt_q[AW-1:0];
								state_q <= S_PRD;
							end
						end else begin
							if (cnt_q == CW'(0)) begin
								status_q <= ST_EMPTY;
							end else if (cnt_q == CW'(1)) begin
								top_q <= '0;
								cnt_q <= '0;
							end else begin
								idx_q   <= AW'(1);
								state_q <= S_QRD;
							end
						end
					end
				end
				S_PRD: begin
					state_q <= S_PCMP;
				end
				S_PCMP: begin
					if (gt) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_DONE;
					end else if (idx_q == AW'(1)) begin
						state_q <= S_PLAST;
					end else begin
						idx_q   <= idx_q - AW'(1);
						state_q <= S_PRD;
					end
				end
				S_PLAST: begin
					top_q   <= val_q;
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_DONE;
				end
				S_QRD: begin
					state_q <= S_QWR;
				end
				S_QWR: begin
					if (idx_q == AW'(1)) begin
						top_q <= rd_data;
					end
					if (CW'(idx_q) == cnt_q - CW'(1)) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_QRD;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(CAPACITY), "count above capacity")
	`ASSERT_PROP(a_full_status, clk, arst_n, (res_valid && status_q == ST_FULL |-> cnt_q == CW'(CAPACITY)), "full status with free space")
	`ASSERT_PROP(a_empty_status, clk, arst_n, (res_valid && status_q == ST_EMPTY |-> cnt_q == CW'(0)), "empty status with stored values")
	`ASSERT_PROP(a_res_hold, clk, arst_n, (res_valid && !res_ready |=> res_valid && $stable(result)), "result changed while stalled")

endmodule

// ----- hdl/sorted_priority_queue_top.sv -----
// Max-first priority queue over signed 32-bit values, held sorted in a RAM.
// Input stream: s_tuser is the opcode (0 push s_tdata, 1 pop the largest).
// Output stream: one transaction per input transaction with the top value,
// the entry count, an empty flag and a status (ok, push rejected when full,
// pop on empty). Equal values leave newest first.
// Steps: a push reads (S_PRD) and compares/writes (S_PCMP) each slot it
// moves, and S_PLAST writes the value at the head if it gets there; a pop
// reads (S_QRD) and writes (S_QWR) each slot. Both use the single RAM port
// pair and the result is then registered; s_tready is low while an item runs.
// A new input transaction is accepted while the previous result waits in the
// output register; if the receiver keeps m_tready low, the next result holds
// in the sequencer and input stays blocked until the register drains.
// Reset clears the count and the control state; RAM contents are not cleared
// and only slots below the count are ever read.
module sorted_priority_queue_top #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[31:0]
	input  logic        s_tuser,  // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // top_value[31:0], entry_count[36:32],
	                              // is_empty[37], status[39:38]
);
	import spq_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic                idle;
	logic                res_valid;
	logic                res_ready;
	spq_result_t         result;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [VALUE_W-1:0]  wr_data;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [VALUE_W-1:0]  rd_data;
	logic                out_valid_q;
	spq_result_t         out_q;

	assign s_tready  = idle;
	assign res_ready = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	spq_core #(.CAPACITY(CAPACITY)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (s_tvalid && idle),
		.start_opcode (s_tuser),
		.start_value  (s_tdata),
		.idle         (idle),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

	spq_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= result;
		end
	end

endmodule
